// ===== design/assert_macros.svh =====
// Assertion macros shared by the pileup counter RTL.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An antecedent that holds in a cycle implies the consequent in that cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// An antecedent that holds in a cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/pbqh_pkg.sv =====
// Package of the pileup base and quality counter: sizes, codes and item types.
// Used by pileup_base_quality_histogram; depends on nothing.
package pbqh_pkg;

  localparam int FILES         = 4;
  localparam int SLOTS         = 64;
  localparam int QUALITY_BINS  = 94;
  localparam int SEQ_BINS      = 5;
  localparam int BINS_PER_FILE = SEQ_BINS + QUALITY_BINS;
  localparam int STORE_DEPTH   = SLOTS * FILES * BINS_PER_FILE;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int SLOT_W        = 6;
  localparam int NSLOT_W       = 7;

  // Operation codes.
  localparam logic [2:0] OP_BEGIN    = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_END      = 3'd2;
  localparam logic [2:0] OP_READ_BIN = 3'd3;
  localparam logic [2:0] OP_NEW_BATCH = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_BAD_BASE = 3'd2;
  localparam logic [2:0] ST_BAD_QUAL = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUAL_FLOOR       = 3'd0;
  localparam logic [2:0] REG_DEPTH_FLOOR      = 3'd1;
  localparam logic [2:0] REG_COUNT_BASES      = 3'd2;
  localparam logic [2:0] REG_COUNT_QUALITIES  = 3'd3;
  localparam logic [2:0] REG_EVERY_POSITION   = 3'd4;
  localparam logic [2:0] REG_REGION_START     = 3'd5;
  localparam logic [2:0] REG_REGION_END       = 3'd6;
  localparam logic [2:0] REG_BATCH_SIZE       = 3'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [30:0] position;
    logic [15:0] depth;
    logic [1:0]  file_index;
    logic [3:0]  base_code;
    logic [7:0]  quality;
    logic        is_deletion;
    logic        ref_skip;
    logic [5:0]  slot;
    logic [6:0]  bin;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        kept;
    logic [5:0]  slot_used;
    logic [30:0] position_out;
    logic [15:0] count;
    logic        batch_full;
  } rsp_t;

  // Nucleotide bin of a 4-bit base code; valid low for codes that are no base.
  typedef struct packed {
    logic       valid;
    logic [2:0] idx;
  } base_bin_t;

  function automatic base_bin_t base_bin(input logic [3:0] code);
    base_bin_t b;
    b = '{valid: 1'b1, idx: 3'd0};
    case (code)
      4'd1:    b.idx = 3'd0;
      4'd2:    b.idx = 3'd1;
      4'd4:    b.idx = 3'd2;
      4'd8:    b.idx = 3'd3;
      4'd15:   b.idx = 3'd4;
      default: b.valid = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== design/pileup_base_quality_histogram.sv =====
// Pileup base and quality counter: top level with the bin memory and its sequencer.
// Depends on pbqh_pkg and assert_macros.svh.
//
// Usage: an item on cmd is taken at a rising edge with start high and busy low.
// Every item gives exactly one result on rsp, shown for one cycle with rsp_valid
// high; the receiver cannot stall, so it must take the result in that cycle.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, and writes are meant to be made while the block is idle.
// Items that touch no bin give their result in the cycle after the transfer. A
// read item that bumps one bin goes through S_RD and S_WR first; one that bumps
// both its base and its quality bin goes through them twice. A read-bin item with
// a valid bin goes through them once; one with an out-of-range bin touches no bin.
// The rate is set by the single-port read-modify-write of the count memory: a
// bump is a read in S_RD followed by a write in S_WR, and busy stays high meanwhile.
// After reset the count memory is cleared one entry per cycle, all 25344 entries,
// during which busy is high; configuration writes are still taken.
module pileup_base_quality_histogram (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pbqh_pkg::cmd_t cmd,
  output logic          rsp_valid,
  output pbqh_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [30:0]   cfg_data
);
  import pbqh_pkg::*;

`include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;

  // Configuration registers.
  logic [7:0]  qual_floor;
  logic [15:0] depth_floor;
  logic        count_bases;
  logic        count_qualities;
  logic        every_position_mode;
  logic [30:0] region_start;
  logic [30:0] region_end;
  logic [6:0]  batch_size;

  // Position state.
  logic [30:0]        current_position;
  logic               position_active;
  logic               depth_ok;
  logic               live_read_seen;
  logic [NSLOT_W-1:0] next_slot;

  // Sequencer state.
  logic [2:0]        state;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr2;
  logic              second_pending;
  logic              clear_op;
  logic [15:0]       rdata;
  logic [15:0]       mem [STORE_DEPTH];

  // Decode results.
  logic               accept;
  logic [6:0]         eff_batch;
  logic [30:0]        tpos;
  logic [30:0]        off;
  logic [2:0]         tstat;
  logic [SLOT_W-1:0]  tslot;
  base_bin_t          bb;
  logic [ADDR_W-1:0]  row_base;
  logic [ADDR_W-1:0]  bin_addr;
  rsp_t               rsp_next;
  logic               position_active_next;
  logic               depth_ok_next;
  logic               live_read_seen_next;
  logic [30:0]        current_position_next;
  logic [NSLOT_W-1:0] next_slot_next;
  logic               bump_a;
  logic               bump_b;
  logic               rd_clear;
  logic [ADDR_W-1:0]  addr_a;
  logic [ADDR_W-1:0]  addr_b;
  logic               mem_we;
  logic [15:0]        mem_wdata;
  logic [15:0]        sat_inc;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      qual_floor          <= 8'd0;
      depth_floor         <= 16'd0;
      count_bases         <= 1'b1;
      count_qualities     <= 1'b0;
      every_position_mode <= 1'b0;
      region_start        <= 31'd1;
      region_end          <= 31'd1;
      batch_size          <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUAL_FLOOR:       qual_floor          <= cfg_data[7:0];
        REG_DEPTH_FLOOR:      depth_floor         <= cfg_data[15:0];
        REG_COUNT_BASES:      count_bases         <= cfg_data[0];
        REG_COUNT_QUALITIES:  count_qualities     <= cfg_data[0];
        REG_EVERY_POSITION:   every_position_mode <= cfg_data[0];
        REG_REGION_START:     region_start        <= cfg_data;
        REG_REGION_END:       region_end          <= cfg_data;
        REG_BATCH_SIZE:       batch_size          <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Decode of one item: target slot, status, state updates and bin addresses.
  always_comb begin
    eff_batch = (batch_size < 7'(SLOTS)) ? batch_size : 7'(SLOTS);
    tpos = (cmd.operation == OP_BEGIN) ? cmd.position : current_position;
    off  = tpos - region_start;
    tslot = '0;
    if (tpos < region_start || tpos > region_end) begin
      tstat = ST_IGNORED;
    end else if (every_position_mode) begin
      if (off >= 31'(eff_batch)) begin
        tstat = ST_FULL;
      end else begin
        tstat = ST_OK;
        tslot = off[SLOT_W-1:0];
      end
    end else if (next_slot >= eff_batch) begin
      tstat = ST_FULL;
    end else begin
      tstat = ST_OK;
      tslot = next_slot[SLOT_W-1:0];
    end

    bb = base_bin(cmd.base_code);

    rsp_next = '0;
    rsp_next.status = ST_IGNORED;
    position_active_next  = position_active;
    depth_ok_next         = depth_ok;
    live_read_seen_next   = live_read_seen;
    current_position_next = current_position;
    next_slot_next        = next_slot;
    bump_a   = 1'b0;
    bump_b   = 1'b0;
    rd_clear = 1'b0;

    // Row of bins for one slot and file; the read-bin item names its own slot.
    if (cmd.operation == OP_READ_BIN) begin
      row_base = ADDR_W'((32'(cmd.slot) * FILES + 32'(cmd.file_index)) * BINS_PER_FILE);
    end else begin
      row_base = ADDR_W'((32'(tslot) * FILES + 32'(cmd.file_index)) * BINS_PER_FILE);
    end
    addr_a   = row_base + ADDR_W'(bb.idx);
    addr_b   = row_base + ADDR_W'(SEQ_BINS) + ADDR_W'(cmd.quality);
    bin_addr = row_base + ADDR_W'(cmd.bin);

    case (cmd.operation)
      OP_BEGIN: begin
        current_position_next = cmd.position;
        position_active_next  = 1'b1;
        depth_ok_next         = (cmd.depth >= depth_floor);
        live_read_seen_next   = 1'b0;
        rsp_next.status       = tstat;
      end
      OP_READ: begin
        if (position_active && 32'(cmd.file_index) < FILES) begin
          if (!cmd.is_deletion && !cmd.ref_skip) begin
            live_read_seen_next = 1'b1;
          end
          if (tstat == ST_OK && depth_ok && !cmd.is_deletion && !cmd.ref_skip &&
              cmd.quality >= qual_floor) begin
            if (count_bases && !bb.valid) begin
              rsp_next.status = ST_BAD_BASE;
            end else if (count_qualities && 32'(cmd.quality) >= QUALITY_BINS) begin
              rsp_next.status = ST_BAD_QUAL;
            end else begin
              rsp_next.status = ST_OK;
              bump_a = count_bases;
              bump_b = count_qualities;
            end
          end
        end
      end
      OP_END: begin
        if (position_active) begin
          rsp_next.status = tstat;
          if (tstat == ST_OK && depth_ok && (every_position_mode || live_read_seen)) begin
            rsp_next.kept         = 1'b1;
            rsp_next.slot_used    = tslot;
            rsp_next.position_out = current_position;
            next_slot_next        = NSLOT_W'(tslot) + NSLOT_W'(1);
          end
          position_active_next = 1'b0;
        end
      end
      OP_READ_BIN: begin
        if (32'(cmd.slot) < SLOTS && 32'(cmd.file_index) < FILES &&
            32'(cmd.bin) < BINS_PER_FILE) begin
          rsp_next.status = ST_OK;
          rd_clear = 1'b1;
        end
      end
      OP_NEW_BATCH: begin
        next_slot_next       = '0;
        position_active_next = 1'b0;
        rsp_next.status      = ST_OK;
      end
      default: ;
    endcase
    rsp_next.batch_full = (next_slot_next >= eff_batch);
  end

  // Memory write: zero during the clearing pass and read-out, else saturating add.
  assign sat_inc   = (rdata == 16'hFFFF) ? rdata : rdata + 16'd1;
  assign mem_we    = (state == S_CLEAR) || (state == S_WR);
  assign mem_wdata = (state == S_CLEAR || clear_op) ? 16'd0 : sat_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  // Sequencer and position state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      addr             <= '0;
      rsp_valid        <= 1'b0;
      second_pending   <= 1'b0;
      clear_op         <= 1'b0;
      current_position <= '0;
      position_active  <= 1'b0;
      depth_ok         <= 1'b0;
      live_read_seen   <= 1'b0;
      next_slot        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          rsp_valid <= 1'b0;
          if (addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          // Items that touch no bin answer in the cycle after the transfer.
          rsp_valid <= accept && !rd_clear && !bump_a && !bump_b;
          if (accept) begin
            rsp              <= rsp_next;
            current_position <= current_position_next;
            position_active  <= position_active_next;
            depth_ok         <= depth_ok_next;
            live_read_seen   <= live_read_seen_next;
            next_slot        <= next_slot_next;
            clear_op         <= rd_clear;
            addr2            <= addr_b;
            second_pending   <= bump_a && bump_b;
            if (rd_clear) begin
              addr  <= bin_addr;
              state <= S_RD;
            end else if (bump_a) begin
              addr  <= addr_a;
              state <= S_RD;
            end else if (bump_b) begin
              addr  <= addr_b;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          rsp_valid <= 1'b0;
          state     <= S_WR;
        end
        S_WR: begin
          rsp_valid <= !second_pending;
          if (clear_op) begin
            rsp.count <= rdata;
          end
          if (second_pending) begin
            second_pending <= 1'b0;
            addr           <= addr2;
            state          <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          rsp_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only shown once the sequencer is back to idle.
  `ASSERT_IMPLY(a_rsp_idle, clk, rst, rsp_valid, !busy)
  // A write-back either starts the second bump or finishes the item.
  `ASSERT_NEXT(a_wr_next, clk, rst, state == S_WR, state == S_RD || rsp_valid)
  // A kept position always comes with an ok status.
  `ASSERT_IMPLY(a_kept_ok, clk, rst, rsp_valid && rsp.kept, rsp.status == ST_OK)
  // The packed slot pointer never runs past the slot count.
  `ASSERT_IMPLY(a_slot_range, clk, rst, 1'b1, 32'(next_slot) <= SLOTS)

endmodule
